@@ rtl/tsv_pkg.sv @@
package tsv_pkg;

  localparam int          SCREEN_HEIGHT_DEF = 240;
  localparam logic [7:0]  THRESH_RESET      = 8'd8;
  localparam logic [6:0]  VOL_MAX           = 7'd100;
  localparam int          COORD_W           = 10;
  localparam int          VOL_W             = 7;
  localparam int          BAR_W             = 10;
  localparam int          IN_DATA_W         = 32;
  localparam int          OUT_DATA_W        = 24;

  typedef struct packed {
    logic [VOL_W-1:0]   speaker_volume;
    logic [COORD_W-1:0] touch_y;
    logic [COORD_W-1:0] touch_x;
    logic               pressed;
  } sample_t;

  typedef struct packed {
    logic [BAR_W-1:0] bar_height;
    logic             overlay_hide;
    logic             overlay_show;
    logic             volume_commit;
    logic [VOL_W-1:0] volume;
    logic             volume_changed;
  } result_t;

  typedef struct packed {
    logic               was_pressed;
    logic               tracking;
    logic               gesture_active;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [VOL_W-1:0]   start_level;
    logic [VOL_W-1:0]   current_level;
  } gest_state_t;

endpackage

@@ rtl/touch_swipe_volume_gesture.sv @@
// channel   | direction | handshake            | payload
// in_       | input     | in_tvalid/in_tready  | touch sample, 28 bits in in_tdata
// out_      | output    | out_tvalid/out_tready| one result word, 21 bits in out_tdata
// cfg_      | input     | cfg_wr_en            | activation threshold, 8 bits
//
// one word per cycle while out_tready is high; each sample is finished in the cycle
// it is accepted and its result sits in the output register from the next cycle on
// in_tready drops only while the output register holds a word not yet taken
// the volume scaling is one constant multiply, the bar height a constant table
// synchronous active-low reset clears the gesture state, threshold goes to 8
module touch_swipe_volume_gesture
  import tsv_pkg::*;
#(
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // pressed, touch_x, touch_y, speaker_volume, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // volume_changed, volume, volume_commit, overlay_show, overlay_hide, bar_height, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [7:0]            cfg_wr_data
);

  gest_state_t st_r;
  gest_state_t st_nxt;
  result_t     res_nxt;
  result_t     res_r;
  sample_t     smp;
  logic        out_valid_r;
  logic [7:0]  thresh_r;
  logic        in_acc;

  assign smp       = sample_t'(in_tdata[$bits(sample_t)-1:0]);
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  tsv_core #(
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_core (
    .st     (st_r),
    .smp    (smp),
    .thresh (thresh_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
      thresh_r    <= THRESH_RESET;
    end else begin
      if (cfg_wr_en) begin
        thresh_r <= cfg_wr_data;
      end
      if (in_acc) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - $bits(result_t))'(0), res_r};

  a_vol_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res_r.volume <= VOL_MAX)
    else $error("volume out of range");

  a_commit_hide: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_r.volume_commit |-> res_r.overlay_hide)
    else $error("commit without hide");

  a_show_sets_active: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && res_nxt.overlay_show |=> st_r.gesture_active)
    else $error("show did not activate gesture");

  a_active_tracking: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.gesture_active |-> st_r.tracking)
    else $error("active gesture without tracking");

  a_change_vol: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && res_nxt.volume_changed |=> st_r.current_level == $past(res_nxt.volume))
    else $error("changed volume not stored");

endmodule

@@ rtl/tsv_core.sv @@
module tsv_core
  import tsv_pkg::*;
#(
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  gest_state_t st,
  input  sample_t     smp,
  input  logic [7:0]  thresh,
  output gest_state_t st_nxt,
  output result_t     res
);

  // floor(100*a/H) as a*K >> SHIFT, exact for 100*a below 2**17
  localparam int             SHIFT = 17 + $clog2(SCREEN_HEIGHT);
  localparam longint         RECIP = ((longint'(1) << SHIFT) + SCREEN_HEIGHT - 1) / SCREEN_HEIGHT;
  localparam longint         K_MUL = 100 * RECIP;
  localparam int             KW    = $clog2(K_MUL + 1);
  localparam int             PW    = COORD_W + KW;
  localparam int             QW    = $clog2((100 * 1023) / SCREEN_HEIGHT + 1);

  logic [BAR_W-1:0]     bar_lut [0:(1 << VOL_W) - 1];
  logic signed [COORD_W:0] dy;
  logic signed [COORD_W:0] dx;
  logic [COORD_W-1:0]   ady;
  logic [COORD_W-1:0]   adx;
  logic [PW-1:0]        prod;
  logic [QW-1:0]        q;
  logic [QW-1:0]        sl_ext;
  logic [QW:0]          sum;
  logic [VOL_W-1:0]     target;
  logic [VOL_W-1:0]     sv_sat;
  logic                 go;

  for (genvar i = 0; i < (1 << VOL_W); i++) begin : g_bar
    localparam int BAR = (i * SCREEN_HEIGHT) / 100;
    assign bar_lut[i] = BAR_W'(BAR);
  end

  assign dy  = $signed({1'b0, st.start_y}) - $signed({1'b0, smp.touch_y});
  assign dx  = $signed({1'b0, smp.touch_x}) - $signed({1'b0, st.start_x});
  assign ady = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
  assign adx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];

  assign prod   = PW'(ady) * PW'(K_MUL);
  assign q      = QW'(prod >> SHIFT);
  assign sl_ext = QW'(st.start_level);
  assign sum    = (QW + 1)'(sl_ext) + (QW + 1)'(q);
  assign sv_sat = (smp.speaker_volume > VOL_MAX) ? VOL_MAX : smp.speaker_volume;

  // truncation toward zero: scale the magnitude, then apply the sign
  always_comb begin
    if (dy[COORD_W]) begin
      target = (q >= sl_ext) ? '0 : VOL_W'(sl_ext - q);
    end else begin
      target = (sum > (QW + 1)'(VOL_MAX)) ? VOL_MAX : VOL_W'(sum);
    end
  end

  always_comb begin
    st_nxt             = st;
    res                = '0;
    go                 = 1'b0;
    st_nxt.was_pressed = smp.pressed;
    if (smp.pressed && !st.was_pressed) begin
      st_nxt.start_x        = smp.touch_x;
      st_nxt.start_y        = smp.touch_y;
      st_nxt.start_level    = sv_sat;
      st_nxt.current_level  = sv_sat;
      st_nxt.tracking       = 1'b1;
      st_nxt.gesture_active = 1'b0;
    end else if (smp.pressed && st.tracking) begin
      go = st.gesture_active || (ady >= COORD_W'(thresh) && ady >= adx);
      if (!st.gesture_active && go) begin
        st_nxt.gesture_active = 1'b1;
        res.overlay_show      = 1'b1;
      end
      if (go && target != st.current_level) begin
        st_nxt.current_level = target;
        res.volume_changed   = 1'b1;
      end
    end else if (!smp.pressed && st.was_pressed) begin
      res.volume_commit     = st.tracking && st.gesture_active;
      res.overlay_hide      = st.gesture_active;
      st_nxt.tracking       = 1'b0;
      st_nxt.gesture_active = 1'b0;
    end
    res.volume     = st_nxt.current_level;
    res.bar_height = bar_lut[st_nxt.current_level];
  end

endmodule
